// ----- design/dsd_pkg.sv -----
package dsd_pkg;

  // Fixed-point format of the normal, the ratio and the outgoing direction.
  localparam int FRAC_BITS = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = 1 << (FRAC_BITS - 1);
  localparam int OUT_MAX   = 131071;
  localparam int OUT_MIN   = -131072;
  localparam logic [47:0] ONE2 = 48'd1 << (2 * FRAC_BITS);

  // Input direction is normalized until its largest magnitude reaches this bit.
  localparam int NORM_BIT = 22;

  // Configuration register and its reset value.
  localparam logic REG_INDEX  = 1'b0;
  localparam logic [17:0] INDEX_RESET = 18'd98304;

  // Stage numbers of the scatter pipeline.
  localparam int S_MAX       = 1;
  localparam int S_LZ        = 2;
  localparam int S_SHIFT     = 3;
  localparam int S_SQUARE    = 4;
  localparam int S_SUM       = 5;
  localparam int S_SQA_FIRST = 6;
  localparam int S_SQA_LAST  = 38;
  localparam int S_DIVSET    = 39;
  localparam int S_DIV_FIRST = 40;
  localparam int S_DIV_LAST  = 57;
  localparam int S_SIGN      = 58;
  localparam int S_DOT       = 59;
  localparam int S_ACC       = 60;
  localparam int S_DN        = 61;
  localparam int S_COS       = 62;
  localparam int S_COS2      = 63;
  localparam int S_SQB_FIRST = 64;
  localparam int S_SQB_LAST  = 80;
  localparam int S_P2        = 64;
  localparam int S_P4A       = 65;
  localparam int S_P4        = 66;
  localparam int S_P5A       = 67;
  localparam int S_P5        = 68;
  localparam int S_RA        = 69;
  localparam int S_RR        = 70;
  localparam int S_SIN       = 81;
  localparam int S_REFL      = 82;
  localparam int S_TT        = 83;
  localparam int S_K         = 84;
  localparam int S_SQC_FIRST = 85;
  localparam int S_SQC_LAST  = 101;
  localparam int S_COEF      = 102;
  localparam int S_CN        = 103;
  localparam int S_RF        = 104;
  localparam int S_OUT       = 105;
  localparam int PIPE_LAST   = 105;

  // States of the ratio and base reflectance precompute.
  typedef enum logic [2:0] {
    PC_LOAD = 3'b001,
    PC_DIV  = 3'b010,
    PC_IDLE = 3'b100
  } pc_state_t;

  typedef enum logic [2:0] {
    PH_RATIO = 3'b001,
    PH_R0F   = 3'b010,
    PH_R0B   = 3'b100
  } pc_phase_t;

  // One ray as it travels down the pipeline; signed fields are read with $signed.
  typedef struct packed {
    logic              zero;
    logic              front;
    logic              refl;
    logic [15:0]       rnd;
    logic [2:0]        neg;
    logic [2:0][17:0]  n;
    logic [17:0]       ratio;
    logic [16:0]       r0n;
    logic [16:0]       r0;
    logic [2:0][23:0]  a;
    logic [23:0]       mx;
    logic [4:0]        sh;
    logic [2:0][47:0]  sq;
    logic [64:0]       rem;
    logic [32:0]       root;
    logic [32:0]       q;
    logic [2:0][49:0]  drem;
    logic [2:0][17:0]  dq;
    logic [2:0][18:0]  u;
    logic [2:0][47:0]  pa;
    logic [2:0][47:0]  pb;
    logic [47:0]       acc;
    logic [23:0]       dn;
    logic [17:0]       cosv;
    logic [17:0]       p;
    logic [39:0]       pp;
    logic [23:0]       pr;
    logic [23:0]       rr;
    logic [47:0]       rcp;
    logic [23:0]       rc;
    logic [2:0][31:0]  ru;
    logic [2:0][31:0]  ro;
    logic [2:0][31:0]  rf;
    logic [34:0]       ts;
    logic [19:0]       t;
    logic [39:0]       tt;
    logic [23:0]       coef;
    logic [2:0][17:0]  o;
  } item_t;

  function automatic logic signed [47:0] smul(input logic signed [47:0] x,
                                              input logic signed [47:0] y);
    return x * y;
  endfunction

  function automatic logic [47:0] umul(input logic [47:0] x, input logic [47:0] y);
    return x * y;
  endfunction

  // Round to nearest by FRAC_BITS, halves away from zero.
  function automatic logic signed [47:0] rshr(input logic signed [47:0] v);
    logic [47:0] m;
    m = v[47] ? (48'd0 - v) : v;
    m = (m + 48'(HALF)) >> FRAC_BITS;
    return v[47] ? $signed(48'd0 - m) : $signed(m);
  endfunction

  function automatic logic [17:0] sat18(input logic signed [31:0] v);
    logic [17:0] r;
    if (v > OUT_MAX) r = 18'(OUT_MAX);
    else if (v < OUT_MIN) r = 18'(OUT_MIN);
    else r = v[17:0];
    return r;
  endfunction

  // Work of one pipeline stage; s is a constant at each instance.
  function automatic item_t stage_step(input int s, input item_t i);
    item_t o;
    int k;
    int b;
    int c;
    logic [66:0] cand;
    logic [50:0] dcand;
    logic [49:0] ssum;
    logic signed [23:0] nd;
    logic signed [18:0] pw;
    logic signed [47:0] w;
    o = i;
    k = 0;
    cand = '0;
    dcand = '0;
    ssum = '0;
    nd = '0;
    pw = '0;
    w = '0;

    // Largest magnitude, zero check and base reflectance square.
    if (s == S_MAX) begin
      o.mx = i.a[0];
      if (i.a[1] > o.mx) o.mx = i.a[1];
      if (i.a[2] > o.mx) o.mx = i.a[2];
      o.zero = (o.mx == '0);
      o.r0 = 17'((umul(48'(i.r0n), 48'(i.r0n)) + 48'(HALF)) >> FRAC_BITS);
    end

    // Normalizing shift amount.
    if (s == S_LZ) begin
      o.sh = '0;
      for (c = 1; c <= NORM_BIT; c++) begin
        if (i.mx < (24'd1 << (NORM_BIT + 1 - c))) o.sh = 5'(c);
      end
    end

    if (s == S_SHIFT) begin
      for (b = 0; b < 3; b++) o.a[b] = i.a[b] << i.sh;
    end

    if (s == S_SQUARE) begin
      for (b = 0; b < 3; b++) o.sq[b] = umul(48'(i.a[b]), 48'(i.a[b]));
    end

    // Squared length, scaled for the length square root.
    if (s == S_SUM) begin
      ssum = 50'(i.sq[0]) + 50'(i.sq[1]) + 50'(i.sq[2]);
      o.rem = 65'(ssum) << 16;
      o.root = '0;
    end

    // One result bit of a square root per stage.
    if ((s >= S_SQA_FIRST && s <= S_SQA_LAST) || (s >= S_SQB_FIRST && s <= S_SQB_LAST) ||
        (s >= S_SQC_FIRST && s <= S_SQC_LAST)) begin
      if (s <= S_SQA_LAST) k = S_SQA_LAST - s;
      else if (s <= S_SQB_LAST) k = S_SQB_LAST - s;
      else k = S_SQC_LAST - s;
      cand = (67'(i.root) << (k + 1)) + (67'd1 << (2 * k));
      if (67'(i.rem) >= cand) begin
        o.rem = i.rem - cand[64:0];
        o.root = i.root | (33'd1 << k);
      end
    end

    // Set up the three component divisions by the length.
    if (s == S_DIVSET) begin
      o.q = i.root;
      for (b = 0; b < 3; b++) begin
        o.drem[b] = (50'(i.a[b]) << (FRAC_BITS + 8)) + 50'(i.root >> 1);
        o.dq[b] = '0;
      end
    end

    // One quotient bit per stage in each lane.
    if (s >= S_DIV_FIRST && s <= S_DIV_LAST) begin
      k = S_DIV_LAST - s;
      dcand = 51'(i.q) << k;
      for (b = 0; b < 3; b++) begin
        if (51'(i.drem[b]) >= dcand) begin
          o.drem[b] = i.drem[b] - dcand[49:0];
          o.dq[b] = i.dq[b] | (18'd1 << k);
        end
      end
    end

    if (s == S_SIGN) begin
      for (b = 0; b < 3; b++)
        o.u[b] = i.neg[b] ? (19'd0 - {1'b0, i.dq[b]}) : {1'b0, i.dq[b]};
    end

    if (s == S_DOT) begin
      for (b = 0; b < 3; b++) o.pa[b] = smul($signed(i.u[b]), $signed(i.n[b]));
    end

    if (s == S_ACC) o.acc = i.pa[0] + i.pa[1] + i.pa[2];

    if (s == S_DN) begin
      w = rshr($signed(i.acc));
      o.dn = w[23:0];
    end

    // Cosine of incidence, clamped to one.
    if (s == S_COS) begin
      nd = -$signed(i.dn);
      if (nd > ONE) o.cosv = 18'(ONE);
      else if (nd < -ONE) o.cosv = 18'(-ONE);
      else o.cosv = nd[17:0];
    end

    // Products that hang off the cosine and the unit direction.
    if (s == S_COS2) begin
      w = smul($signed(i.cosv), $signed(i.cosv));
      o.rem = 65'(ONE2 - w);
      o.root = '0;
      pw = 19'sd65536 - $signed(i.cosv);
      o.p = pw[17:0];
      o.pp = 40'(umul(48'(o.p), 48'(o.p)));
      o.rcp = smul($signed({1'b0, i.ratio}), $signed(i.cosv));
      for (b = 0; b < 3; b++) begin
        o.pa[b] = smul($signed({1'b0, i.ratio}), $signed(i.u[b]));
        o.pb[b] = smul($signed(i.dn), $signed(i.n[b]));
      end
    end

    // Rounded products and the reflected direction.
    if (s == S_P2) begin
      o.pr = 24'((i.pp + 40'(HALF)) >> FRAC_BITS);
      w = rshr($signed(i.rcp));
      o.rc = w[23:0];
      for (b = 0; b < 3; b++) begin
        w = rshr($signed(i.pa[b]));
        o.ru[b] = w[31:0];
        w = rshr($signed(i.pb[b]) <<< 1);
        o.ro[b] = 32'($signed(i.u[b]) - w);
      end
    end

    // Schlick power chain.
    if (s == S_P4A) o.pp = 40'(umul(48'(i.pr), 48'(i.pr)));
    if (s == S_P4) o.pr = 24'((i.pp + 40'(HALF)) >> FRAC_BITS);
    if (s == S_P5A) o.pp = 40'(umul(48'(i.pr), 48'(i.p)));
    if (s == S_P5) o.pr = 24'((i.pp + 40'(HALF)) >> FRAC_BITS);
    if (s == S_RA) o.pp = 40'(umul(48'(ONE) - 48'(i.r0), 48'(i.pr)));
    if (s == S_RR) o.rr = 24'(i.r0) + 24'((i.pp + 40'(HALF)) >> FRAC_BITS);

    if (s == S_SIN) o.ts = 35'(umul(48'(i.ratio), 48'(i.root[16:0])));

    // Reflect on total internal reflection or when reflectance beats the draw.
    if (s == S_REFL) begin
      o.refl = (48'(i.ts) > ONE2) || (i.rr > 24'(i.rnd));
      o.t = 20'((i.ts + 35'(HALF)) >> FRAC_BITS);
    end

    if (s == S_TT) o.tt = 40'(umul(48'(i.t), 48'(i.t)));

    if (s == S_K) begin
      o.rem = (48'(i.tt) < ONE2) ? 65'(ONE2 - 48'(i.tt)) : '0;
      o.root = '0;
    end

    // Refracted direction.
    if (s == S_COEF) o.coef = 24'($signed(i.rc) - $signed({1'b0, i.root[16:0]}));

    if (s == S_CN) begin
      for (b = 0; b < 3; b++) o.pa[b] = smul($signed(i.coef), $signed(i.n[b]));
    end

    if (s == S_RF) begin
      for (b = 0; b < 3; b++) begin
        w = rshr($signed(i.pa[b]));
        o.rf[b] = 32'($signed(i.ru[b]) + w);
      end
    end

    // Choose, saturate, and force a zero direction to a zero result.
    if (s == S_OUT) begin
      for (b = 0; b < 3; b++)
        o.o[b] = i.zero ? '0 : sat18(i.refl ? $signed(i.ro[b]) : $signed(i.rf[b]));
      o.refl = i.refl & ~i.zero;
    end

    return o;
  endfunction

endpackage

// ----- design/dielectric_scatter_direction.sv -----
// Dielectric scatter direction.
// An input item carries a ray direction of any scale, a unit surface normal in
// Q2.16, a front-face flag and a Q0.16 random draw. The result item carries the
// unit outgoing direction in Q2.16 and a flag that is set when the ray reflects.
// Both channels use valid and stall; an item moves when valid is high and stall
// is low. The refractive index is written over the APB port at address 0.
// Throughput is one item per cycle while in_stall is low. The 105 pipeline
// stages hold a 33-step length square root, an 18-step divider per component
// and two 17-step square roots. After reset and after every index write, a
// serial divider forms the reciprocal ratio and the base reflectances for both
// faces; in_stall stays high while it works. A stalled receiver is absorbed by
// an output register and a skid register: the pipeline freezes once the skid
// register holds an item, and in_stall follows. Reset empties the pipeline and
// restores the index to 1.5.
module dielectric_scatter_direction (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] dir_x,
  input  logic signed [23:0] dir_y,
  input  logic signed [23:0] dir_z,
  input  logic signed [17:0] normal_x,
  input  logic signed [17:0] normal_y,
  input  logic signed [17:0] normal_z,
  input  logic               outside_hit,
  input  logic [15:0]        random_fraction,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] out_x,
  output logic signed [17:0] out_y,
  output logic signed [17:0] out_z,
  output logic               was_reflected,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import dsd_pkg::*;

  logic [17:0] refractive_index;
  logic [17:0] idx_c;
  logic        cfg_wr;

  pc_state_t   state;
  pc_phase_t   phase;
  logic [4:0]  cnt;
  logic [35:0] dvd;
  logic [35:0] dvd_next;
  logic [18:0] dvs;
  logic [16:0] quot;
  logic [16:0] quot_next;
  logic [35:0] dcand;
  logic [17:0] ld_r;
  logic [17:0] ld_num;
  logic [18:0] ld_den;
  logic [35:0] ld_dvd;
  logic [18:0] ld_dvs;
  logic [16:0] ratio_f;
  logic [16:0] r0n_f;
  logic [16:0] r0n_b;
  logic        busy;

  item_t       entry;
  item_t       pipe [PIPE_LAST+1];
  logic [PIPE_LAST:0] pv;
  logic        en;
  logic        push;
  logic        take;
  logic        skid_v;
  logic [17:0] skid_x;
  logic [17:0] skid_y;
  logic [17:0] skid_z;
  logic        skid_r;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_INDEX);
  assign prdata = (paddr[2] == REG_INDEX) ? {14'd0, refractive_index} : 32'd0;
  assign idx_c  = (refractive_index < 18'(ONE)) ? 18'(ONE) : refractive_index;

  // Operands for the next precompute division.
  always_comb begin
    ld_r   = (phase == PH_R0F) ? {1'b0, ratio_f} : idx_c;
    ld_num = (ld_r > 18'(ONE)) ? (ld_r - 18'(ONE)) : (18'(ONE) - ld_r);
    ld_den = 19'(ld_r) + 19'(ONE);
    unique case (phase)
      PH_RATIO: begin
        ld_dvd = 36'(ONE2) + 36'(idx_c >> 1);
        ld_dvs = 19'(idx_c);
      end
      PH_R0F, PH_R0B: begin
        ld_dvd = (36'(ld_num) << FRAC_BITS) + 36'(ld_den >> 1);
        ld_dvs = ld_den;
      end
      default: begin
        ld_dvd = '0;
        ld_dvs = '0;
      end
    endcase
  end

  // One quotient bit per cycle.
  always_comb begin
    dcand = 36'(dvs) << cnt;
    if (dvd >= dcand) begin
      dvd_next  = dvd - dcand;
      quot_next = quot | (17'd1 << cnt);
    end else begin
      dvd_next  = dvd;
      quot_next = quot;
    end
  end

  // Precompute sequencer and the index register.
  always_ff @(posedge clk) begin
    if (rst) begin
      refractive_index <= INDEX_RESET;
      state <= PC_LOAD;
      phase <= PH_RATIO;
      cnt <= '0;
    end else if (cfg_wr) begin
      refractive_index <= pwdata[17:0];
      state <= PC_LOAD;
      phase <= PH_RATIO;
    end else begin
      unique case (state)
        PC_LOAD: begin
          state <= PC_DIV;
          cnt <= 5'd16;
        end
        PC_DIV: begin
          cnt <= cnt - 5'd1;
          if (cnt == '0) begin
            unique case (phase)
              PH_RATIO: begin
                phase <= PH_R0F;
                state <= PC_LOAD;
              end
              PH_R0F: begin
                phase <= PH_R0B;
                state <= PC_LOAD;
              end
              PH_R0B: state <= PC_IDLE;
              default: state <= PC_LOAD;
            endcase
          end
        end
        PC_IDLE: state <= PC_IDLE;
        default: state <= PC_LOAD;
      endcase
    end
  end

  // Divider datapath and precomputed results.
  always_ff @(posedge clk) begin
    if (state == PC_LOAD) begin
      dvd  <= ld_dvd;
      dvs  <= ld_dvs;
      quot <= '0;
    end else if (state == PC_DIV) begin
      dvd  <= dvd_next;
      quot <= quot_next;
      if (cnt == '0) begin
        if (phase == PH_RATIO) ratio_f <= quot_next;
        if (phase == PH_R0F) r0n_f <= quot_next;
        if (phase == PH_R0B) r0n_b <= quot_next;
      end
    end
  end

  assign busy     = (state != PC_IDLE);
  assign en       = ~skid_v;
  assign in_stall = skid_v | busy;

  // Item as it enters the pipeline.
  always_comb begin
    entry       = '0;
    entry.neg   = {dir_z[23], dir_y[23], dir_x[23]};
    entry.a[0]  = dir_x[23] ? (24'd0 - dir_x) : dir_x;
    entry.a[1]  = dir_y[23] ? (24'd0 - dir_y) : dir_y;
    entry.a[2]  = dir_z[23] ? (24'd0 - dir_z) : dir_z;
    entry.n[0]  = normal_x;
    entry.n[1]  = normal_y;
    entry.n[2]  = normal_z;
    entry.front = outside_hit;
    entry.rnd   = random_fraction;
    entry.ratio = outside_hit ? {1'b0, ratio_f} : idx_c;
    entry.r0n   = outside_hit ? r0n_f : r0n_b;
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (en) begin
      pv <= {pv[PIPE_LAST-1:0], in_valid & ~in_stall};
    end
  end

  // Pipeline stages.
  always_ff @(posedge clk) begin
    if (en) pipe[0] <= entry;
  end

  for (genvar g = 1; g <= PIPE_LAST; g++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) pipe[g] <= stage_step(g, pipe[g-1]);
    end
  end

  assign push = en & pv[PIPE_LAST];
  assign take = out_valid & ~out_stall;

  // Output register and skid register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (take) skid_v <= 1'b0;
    end else if (push) begin
      if (out_valid & ~take) skid_v <= 1'b1;
      else out_valid <= 1'b1;
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  // Output register and skid register data.
  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (take) begin
        out_x <= skid_x;
        out_y <= skid_y;
        out_z <= skid_z;
        was_reflected <= skid_r;
      end
    end else if (push) begin
      if (out_valid & ~take) begin
        skid_x <= pipe[PIPE_LAST].o[0];
        skid_y <= pipe[PIPE_LAST].o[1];
        skid_z <= pipe[PIPE_LAST].o[2];
        skid_r <= pipe[PIPE_LAST].refl;
      end else begin
        out_x <= pipe[PIPE_LAST].o[0];
        out_y <= pipe[PIPE_LAST].o[1];
        out_z <= pipe[PIPE_LAST].o[2];
        was_reflected <= pipe[PIPE_LAST].refl;
      end
    end
  end

endmodule

// ----- verif/tb_dielectric_scatter_direction.sv -----
module tb_dielectric_scatter_direction;
  import dsd_pkg::*;

  // Ray and scattered direction as the testbench holds them.
  typedef struct {
    logic signed [23:0] dx, dy, dz;
    logic signed [17:0] nx, ny, nz;
    logic               front;
    logic [15:0]        rnd;
  } ray_t;

  typedef struct {
    logic [17:0] ox, oy, oz;
    logic        refl;
  } scatter_t;

  // One row of the directed table; has_gold marks a result typed in by hand.
  typedef struct {
    ray_t     ray;
    bit       has_gold;
    scatter_t gold;
  } row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [23:0] dir_x, dir_y, dir_z;
  logic signed [17:0] normal_x, normal_y, normal_z;
  logic               outside_hit;
  logic [15:0]        random_fraction;
  logic               out_valid;
  logic               out_stall;
  logic signed [17:0] out_x, out_y, out_z;
  logic               was_reflected;
  logic               psel, penable, pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  dielectric_scatter_direction dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .outside_hit(outside_hit), .random_fraction(random_fraction),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .was_reflected(was_reflected),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  localparam int LATENCY    = 106;
  localparam int WATCHDOG   = 5000;

  logic [17:0] index_reg;
  scatter_t    expected_q[$];
  int          errors;
  int          rays_sent;
  int          rays_seen;
  int          reflections;
  int          idle_cycles;
  int          send_idle_pct;
  int          stall_pct;
  bit          hold_off;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Integer square root, floor, of a 64-bit value.
  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Divide by 2^16 and round, halves away from zero.
  function automatic longint round_q(input longint v);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + HALF) >>> FRAC_BITS;
    return v < 0 ? -m : m;
  endfunction

  function automatic logic [17:0] clip18(input longint v);
    if (v > OUT_MAX) v = OUT_MAX;
    if (v < OUT_MIN) v = OUT_MIN;
    return v[17:0];
  endfunction

  // True when two scattered directions differ in any field.
  function automatic bit scatter_differs(input scatter_t x, input scatter_t y);
    return (x.ox !== y.ox) || (x.oy !== y.oy) || (x.oz !== y.oz) || (x.refl !== y.refl);
  endfunction

  // Predicts the scattered direction of one ray under the current index.
  function automatic scatter_t scatter_ray(input ray_t r);
    scatter_t s;
    longint d[3], n[3], u[3], o[3];
    longint unsigned a[3], mx, lsq, q, m, one, one2, idx, ratio, sinv;
    longint unsigned rnum, rden, r0n, r0, p, p2, p4, p5, rr, rnd, t, k;
    longint dn, cosv, coef;
    int sh;
    bit refl;
    one = ONE;
    one2 = one * one;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    n[0] = r.nx; n[1] = r.ny; n[2] = r.nz;
    mx = 0;
    lsq = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = d[i] < 0 ? -d[i] : d[i];
      if (a[i] > mx) mx = a[i];
    end
    if (mx == 0) begin
      s.ox = '0; s.oy = '0; s.oz = '0; s.refl = 1'b0;
      return s;
    end
    while (mx < (64'd1 << NORM_BIT)) begin
      mx <<= 1;
      sh++;
    end
    for (int i = 0; i < 3; i++) begin
      a[i] <<= sh;
      lsq += a[i] * a[i];
    end
    q = isqrt(lsq << 16);
    for (int i = 0; i < 3; i++) begin
      m = ((a[i] << (FRAC_BITS + 8)) + q / 2) / q;
      u[i] = d[i] < 0 ? -longint'(m) : longint'(m);
    end
    dn = round_q(u[0] * n[0] + u[1] * n[1] + u[2] * n[2]);
    cosv = -dn;
    if (cosv > ONE) cosv = ONE;
    if (cosv < -ONE) cosv = -ONE;
    idx = index_reg < one ? one : index_reg;
    ratio = r.front ? (one2 + idx / 2) / idx : idx;
    sinv = isqrt(one2 - longint'(cosv * cosv));
    rnum = ratio > one ? ratio - one : one - ratio;
    rden = ratio + one;
    r0n = (rnum * one + rden / 2) / rden;
    r0 = (r0n * r0n + HALF) >> FRAC_BITS;
    p = ONE - cosv;
    p2 = (p * p + HALF) >> FRAC_BITS;
    p4 = (p2 * p2 + HALF) >> FRAC_BITS;
    p5 = (p4 * p + HALF) >> FRAC_BITS;
    rr = r0 + (((one - r0) * p5 + HALF) >> FRAC_BITS);
    rnd = r.rnd;
    refl = (ratio * sinv > one2) || (rr > rnd);
    if (refl) begin
      for (int i = 0; i < 3; i++) o[i] = u[i] - round_q(2 * dn * n[i]);
    end else begin
      t = (ratio * sinv + HALF) >> FRAC_BITS;
      k = t * t < one2 ? one2 - t * t : 0;
      coef = round_q(longint'(ratio) * cosv) - longint'(isqrt(k));
      for (int i = 0; i < 3; i++)
        o[i] = round_q(longint'(ratio) * u[i]) + round_q(coef * n[i]);
    end
    s.ox = clip18(o[0]);
    s.oy = clip18(o[1]);
    s.oz = clip18(o[2]);
    s.refl = refl;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [17:0] got,
                                 input logic [17:0] want);
    errors++;
    $display("mismatch on %s at result %0d: got %0h, expected %0h", what, rays_seen, got,
             want);
  endtask

  // Builds a ray from its direction, normal, face flag and random draw.
  function automatic ray_t make_ray(input longint dx, dy, dz, nx, ny, nz,
                                    input bit front, input int rnd);
    ray_t r;
    r.dx = 24'(dx); r.dy = 24'(dy); r.dz = 24'(dz);
    r.nx = 18'(nx); r.ny = 18'(ny); r.nz = 18'(nz);
    r.front = front;
    r.rnd = 16'(rnd);
    return r;
  endfunction

  // Random ray: mostly unit axis or diagonal normals of random sign, some noise.
  function automatic ray_t random_ray();
    ray_t r;
    int axis, sc;
    sc = $urandom_range(0, 23);
    r.dx = $signed(24'($urandom)) >>> sc;
    r.dy = $signed(24'($urandom)) >>> sc;
    r.dz = $signed(24'($urandom)) >>> sc;
    r.nx = '0; r.ny = '0; r.nz = '0;
    case ($urandom_range(0, 9))
      0: begin
        r.nx = 18'(int'($urandom_range(0, 131072)) - 65536);
        r.ny = 18'(int'($urandom_range(0, 131072)) - 65536);
        r.nz = 18'(int'($urandom_range(0, 131072)) - 65536);
      end
      1: begin
        r.nx = 18'($urandom);
        r.ny = 18'($urandom);
        r.nz = 18'($urandom);
      end
      2, 3: begin
        r.nx = $urandom_range(0, 1) ? 18'sd37837 : -18'sd37837;
        r.ny = $urandom_range(0, 1) ? 18'sd37837 : -18'sd37837;
        r.nz = $urandom_range(0, 1) ? 18'sd37837 : -18'sd37837;
      end
      default: begin
        axis = $urandom_range(0, 2);
        if (axis == 0) r.nx = $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536;
        if (axis == 1) r.ny = $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536;
        if (axis == 2) r.nz = $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536;
      end
    endcase
    r.front = 1'($urandom_range(0, 1));
    r.rnd = 16'($urandom);
    return r;
  endfunction

  // Offers one ray and waits until it is taken.
  task automatic send_ray(input ray_t r);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    dir_x <= r.dx; dir_y <= r.dy; dir_z <= r.dz;
    normal_x <= r.nx; normal_y <= r.ny; normal_z <= r.nz;
    outside_hit <= r.front;
    random_fraction <= r.rnd;
    expected_q.push_back(scatter_ray(r));
    rays_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Writes the index over the port once the pipeline is empty.
  task automatic write_index(input logic [17:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {REG_INDEX, 2'b00};
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    index_reg = v;
  endtask

  // Receiver: stalls at random, or holds off for a long stretch on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= stall_pct > 0 && $urandom_range(0, 99) < stall_pct;
    end
  end

  // Result checker against the oldest expectation.
  always @(posedge clk) begin
    scatter_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("result %0d arrived with nothing expected", rays_seen);
      end else begin
        want = expected_q.pop_front();
        if (out_x !== want.ox) report_mismatch("out_x", out_x, want.ox);
        if (out_y !== want.oy) report_mismatch("out_y", out_y, want.oy);
        if (out_z !== want.oz) report_mismatch("out_z", out_z, want.oz);
        if (was_reflected !== want.refl)
          report_mismatch("was_reflected", 18'(was_reflected), 18'(want.refl));
        reflections += was_reflected;
      end
      rays_seen++;
    end
  end

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("dielectric_scatter_direction regression: fail");
      $finish;
    end
  end

  // Pressure: the receiver holds off long enough to back the pipeline up.
  task automatic hold_receiver();
    hold_off = 1'b1;
    repeat (3 * LATENCY) @(posedge clk);
    hold_off = 1'b0;
  endtask

  initial begin
    row_t        rows[$];
    row_t        rw;
    scatter_t    z;
    logic [17:0] settings[6];
    int          per_phase;
    rst = 1'b1;
    in_valid = 1'b0;
    dir_x = 0; dir_y = 0; dir_z = 0;
    normal_x = 0; normal_y = 0; normal_z = 0;
    outside_hit = 0; random_fraction = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    errors = 0; rays_sent = 0; rays_seen = 0; reflections = 0;
    send_idle_pct = 0; stall_pct = 0; hold_off = 0;
    index_reg = INDEX_RESET;
    z.ox = '0; z.oy = '0; z.oz = '0; z.refl = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table: zero direction, extremes, grazing, head-on and odd normals.
    rw.has_gold = 1; rw.gold = z;
    rw.ray = make_ray(0, 0, 0, 0, 65536, 0, 1, 0); rows.push_back(rw);
    rw.ray = make_ray(0, 0, 0, -65536, 65536, 0, 0, 65535); rows.push_back(rw);
    rw.has_gold = 0;
    rw.ray = make_ray(0, -8388608, 0, 0, 65536, 0, 1, 0); rows.push_back(rw);
    rw.ray = make_ray(0, 8388607, 0, 0, 65536, 0, 0, 65535); rows.push_back(rw);
    rw.ray = make_ray(1, -1, 0, 0, 65536, 0, 1, 32768); rows.push_back(rw);
    rw.ray = make_ray(1, -1, 0, 0, 65536, 0, 0, 32768); rows.push_back(rw);
    rw.ray = make_ray(8388607, -1, 0, 0, 65536, 0, 1, 0); rows.push_back(rw);
    rw.ray = make_ray(8388607, -1, 0, 0, 65536, 0, 0, 65535); rows.push_back(rw);
    rw.ray = make_ray(-8388608, -8388608, -8388608, 37837, 37837, 37837, 1, 1000);
    rows.push_back(rw);
    rw.ray = make_ray(3, -4, 5, 0, 0, -65536, 0, 12345); rows.push_back(rw);
    rw.ray = make_ray(100, -200, 0, 131071, 131071, 0, 1, 0); rows.push_back(rw);
    rw.ray = make_ray(-7, 9, -2, -131072, -131072, -131072, 0, 65535); rows.push_back(rw);
    rw.ray = make_ray(5, 6, 7, 10, -20, 30, 1, 40000); rows.push_back(rw);
    rw.ray = make_ray(0, 0, -1, 0, 0, 65536, 0, 0); rows.push_back(rw);
    rw.ray = make_ray(-8388608, 8388607, 1, 0, 65536, 0, 1, 65535); rows.push_back(rw);
    foreach (rows[i]) begin
      send_ray(rows[i].ray);
      if (rows[i].has_gold && scatter_differs(expected_q[$], rows[i].gold)) begin
        errors++;
        $display("predictor disagrees with table row %0d", i);
      end
    end

    // Random phases over several index settings, extremes included.
    settings = '{18'd65536, 18'd262143, 18'd0, 18'd80000, 18'd200000, INDEX_RESET};
    per_phase = 850 / 6;
    foreach (settings[p]) begin
      write_index(settings[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 72; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      if (p == 1) begin
        send_idle_pct = 0;
        fork
          hold_receiver();
          repeat (per_phase) send_ray(random_ray());
        join
        send_idle_pct = 72;
      end else begin
        for (int i = 0; i < per_phase; i++) send_ray(random_ray());
      end
    end
    in_valid <= 1'b0;
    stall_pct = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);

    $display("Sent %0d rays over six index settings; %0d results checked, %0d reflected.",
             rays_sent, rays_seen, reflections);
    if (errors == 0) begin
      $display("dielectric_scatter_direction regression: pass");
    end else begin
      $display("dielectric_scatter_direction regression: fail");
    end
    $finish;
  end

endmodule

// ----- dielectric_scatter_direction.f -----
design/dsd_pkg.sv
design/dielectric_scatter_direction.sv
verif/tb_dielectric_scatter_direction.sv
